[rtl/core/smm_pkg.sv]
// Shared constants, types and microcode program of the square matrix multiply block.
package smm_pkg;

    localparam int MAX_SIDE = 32;
    localparam int IDX_W    = 5;
    localparam int SIDE_W   = 6;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(MAX_SIDE + 1);
    localparam int CMP_W    = (SIDE_W > CNT_W) ? SIDE_W : CNT_W;
    localparam int K_W      = $clog2(MAX_SIDE);
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W   = $clog2(CELLS);

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(32);

    typedef enum logic [1:0] {
        MODE_WRITE_A = 2'd0,
        MODE_WRITE_B = 2'd1,
        MODE_QUERY   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_NO_QUERY = 3'd1,
        COND_SKIP     = 3'd2,
        COND_MORE     = 3'd3,
        COND_OUT_BUSY = 3'd4
    } cond_t;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_FETCH  = 3'd0;
    localparam step_t STEP_QINIT  = 3'd1;
    localparam step_t STEP_QLOOP  = 3'd2;
    localparam step_t STEP_DRAIN1 = 3'd3;
    localparam step_t STEP_DRAIN2 = 3'd4;
    localparam step_t STEP_DONE   = 3'd5;
    localparam step_t STEP_LAST   = STEP_DONE;

    // Datapath controls of one microcode step.
    typedef struct packed {
        logic accept;
        logic clear;
        logic issue;
        logic load_out;
    } ctrl_t;

    // Datapath flags tested by conditional jumps.
    typedef struct packed {
        logic skip;
        logic more;
        logic out_busy;
    } status_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Control store: jump to target when the condition holds, else advance
    // (the last step wraps to fetch).
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t word;
        word = '{ctrl: '0, cond: COND_NEVER, target: STEP_FETCH};
        unique case (step)
            STEP_FETCH: begin
                word.ctrl.accept = 1'b1;
                word.cond        = COND_NO_QUERY;
                word.target      = STEP_FETCH;
            end
            STEP_QINIT: begin
                word.ctrl.clear = 1'b1;
                word.cond       = COND_SKIP;
                word.target     = STEP_DONE;
            end
            STEP_QLOOP: begin
                word.ctrl.issue = 1'b1;
                word.cond       = COND_MORE;
                word.target     = STEP_QLOOP;
            end
            STEP_DRAIN1: begin
                word.cond = COND_NEVER;
            end
            STEP_DRAIN2: begin
                word.cond = COND_NEVER;
            end
            STEP_DONE: begin
                word.ctrl.load_out = 1'b1;
                word.cond          = COND_OUT_BUSY;
                word.target        = STEP_DONE;
            end
            default: begin
                word.cond   = COND_NEVER;
                word.target = STEP_FETCH;
            end
        endcase
        return word;
    endfunction

endpackage

[rtl/core/smm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/smm_seq.sv]
// Microcode sequencer: step counter, control store and conditional jumps.
module smm_seq
    import smm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic [1:0]  s_mode,
    input  status_t     status,
    output ctrl_t       ctrl
);

    step_t  pc_reg;
    step_t  pc_next;
    ucode_t word;
    logic   query_taken;
    logic   take;

    assign word        = ucode_rom(pc_reg);
    assign ctrl        = word.ctrl;
    assign query_taken = s_valid && word.ctrl.accept && (s_mode == MODE_QUERY);

    always_comb begin
        unique case (word.cond)
            COND_NEVER:    take = 1'b0;
            COND_NO_QUERY: take = !query_taken;
            COND_SKIP:     take = status.skip;
            COND_MORE:     take = status.more;
            COND_OUT_BUSY: take = status.out_busy;
            default:       take = 1'b0;
        endcase
    end

    always_comb begin
        priority if (take) begin
            pc_next = word.target;
        end else if (pc_reg == STEP_LAST) begin
            pc_next = STEP_FETCH;
        end else begin
            pc_next = pc_reg + step_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

[rtl/core/smm_datapath.sv]
// Datapath: matrix stores, index counter, multiply-accumulate and result register.
module smm_datapath
    import smm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_t               ctrl,
    input  logic                cfg_wr_en,
    input  logic [SIDE_W-1:0]   cfg_wr_data,
    input  logic                s_valid,
    input  logic [1:0]          s_mode,
    input  logic [IDX_W-1:0]    s_row,
    input  logic [IDX_W-1:0]    s_col,
    input  logic signed [DATA_W-1:0] s_element,
    input  logic                m_ready,
    output status_t             status,
    output logic                m_valid,
    output logic [IDX_W-1:0]    m_out_row,
    output logic [IDX_W-1:0]    m_out_col,
    output logic signed [DATA_W-1:0] m_product
);

    logic [SIDE_W-1:0] side_reg;
    logic [SIDE_W-1:0] side_next;
    logic [CMP_W-1:0]  side_act;

    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              mul_vld_reg, mul_vld_next;
    logic [DATA_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0] acc_reg, acc_next;

    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  out_row_reg, out_row_next;
    logic [IDX_W-1:0]  out_col_reg, out_col_next;
    logic [DATA_W-1:0] product_reg, product_next;

    logic              accept;
    logic              in_range;
    logic              we_a, we_b;
    logic              out_busy;
    logic              load;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] a_raddr, b_raddr;
    logic [DATA_W-1:0] a_rdata, b_rdata;

    assign accept   = s_valid && ctrl.accept;
    assign in_range = (CMP_W'(s_row) < CMP_W'(MAX_SIDE)) && (CMP_W'(s_col) < CMP_W'(MAX_SIDE));
    assign we_a     = accept && in_range && (s_mode == MODE_WRITE_A);
    assign we_b     = accept && in_range && (s_mode == MODE_WRITE_B);
    assign wr_addr  = ADDR_W'(s_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(s_col);
    assign a_raddr  = ADDR_W'(row_reg) * ADDR_W'(MAX_SIDE) + ADDR_W'(k_reg);
    assign b_raddr  = ADDR_W'(k_reg) * ADDR_W'(MAX_SIDE) + ADDR_W'(col_reg);

    // Clamp the configured side to the store size.
    assign side_act = (CMP_W'(side_reg) > CMP_W'(MAX_SIDE)) ? CMP_W'(MAX_SIDE)
                                                            : CMP_W'(side_reg);

    assign out_busy        = m_valid_reg && !m_ready;
    assign load            = ctrl.load_out && !out_busy;
    assign status.out_busy = out_busy;
    assign status.skip     = (CMP_W'(row_reg) >= side_act) || (CMP_W'(col_reg) >= side_act);
    assign status.more     = (CMP_W'(k_reg) + CMP_W'(1)) < side_act;

    smm_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (wr_addr),
        .wdata (s_element),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    smm_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (wr_addr),
        .wdata (s_element),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    always_comb begin
        side_next    = cfg_wr_en ? cfg_wr_data : side_reg;
        row_next     = accept ? s_row : row_reg;
        col_next     = accept ? s_col : col_reg;
        rd_vld_next  = ctrl.issue;
        mul_vld_next = rd_vld_reg;
        prod_next    = a_rdata * b_rdata;

        priority if (ctrl.clear) begin
            k_next = '0;
        end else if (ctrl.issue) begin
            k_next = k_reg + K_W'(1);
        end else begin
            k_next = k_reg;
        end

        priority if (ctrl.clear) begin
            acc_next = '0;
        end else if (mul_vld_reg) begin
            acc_next = acc_reg + prod_reg;
        end else begin
            acc_next = acc_reg;
        end

        out_row_next = load ? row_reg : out_row_reg;
        out_col_next = load ? col_reg : out_col_reg;
        product_next = load ? acc_reg : product_reg;

        priority if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg    <= SIDE_RESET;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            side_reg    <= side_next;
            rd_vld_reg  <= rd_vld_next;
            mul_vld_reg <= mul_vld_next;
            m_valid_reg <= m_valid_next;
        end
        row_reg     <= row_next;
        col_reg     <= col_next;
        k_reg       <= k_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
        product_reg <= product_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_out_row = out_row_reg;
    assign m_out_col = out_col_reg;
    assign m_product = product_reg;

`ifndef SYNTHESIS
    a_drained_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> !rd_vld_reg && !mul_vld_reg)
        else $error("result loaded before the multiply pipeline drained");

    a_issue_in_side: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.issue |-> (CMP_W'(k_reg) < side_act))
        else $error("term index beyond the active side");

    a_clear_after_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_mode == MODE_QUERY)) |=> ctrl.clear && !ctrl.issue)
        else $error("query taken without clearing the accumulator");
`endif

endmodule

[rtl/core/square_matrix_multiply.sv]
// Top level of the square integer matrix multiply block.
//
// Usage:
//   Input channel (s_valid/s_ready, s_mode, s_row, s_col, s_element):
//     mode A or B writes one signed 32-bit element of that matrix at
//     (row, col) in the cycle it is taken; mode query asks for entry
//     (row, col) of A x B; the unused mode code is taken and dropped.
//   Result channel (m_valid/m_ready, m_out_row, m_out_col, m_product):
//     one item per query, product wrapped modulo 2^32.
//   Configuration: cfg_wr_en/cfg_wr_data set the side length; write only
//     while idle. A side above 32 acts as 32; a side of zero gives zero.
// Sequence:
//   A write is taken in the fetch step. A query runs its side terms through
//   one multiply-accumulate fed by the two store read ports, in the steps
//   fetch, setup, term loop, two pipeline drain steps and result load; a query
//   outside the side skips to the result load. One item is in work at a time.
// Reset: synchronous, active low; side returns to 32, the stores keep their
//   contents (undefined until written), the result register empties.
// Stall: a finished result waits in the output register; the next item is
//   still taken, and a following query holds in its last step until the
//   output register frees.
module square_matrix_multiply
    import smm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [SIDE_W-1:0]        cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic [IDX_W-1:0]         s_row,
    input  logic [IDX_W-1:0]         s_col,
    input  logic signed [DATA_W-1:0] s_element,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [IDX_W-1:0]         m_out_row,
    output logic [IDX_W-1:0]         m_out_col,
    output logic signed [DATA_W-1:0] m_product
);

    ctrl_t   ctrl;
    status_t status;

    // The fetch step is the only one that takes an item.
    assign s_ready = ctrl.accept;

    smm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .status  (status),
        .ctrl    (ctrl)
    );

    smm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_mode      (s_mode),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_element   (s_element),
        .m_ready     (m_ready),
        .status      (status),
        .m_valid     (m_valid),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_product   (m_product)
    );

endmodule
